// ----- sv/hciuh4_pkg.sv -----
package hciuh4_pkg;

    // H4 packet type bytes that the deframer recognises.
    localparam logic [7:0] TYPE_ACL = 8'h02;
    localparam logic [7:0] TYPE_EVT = 8'h04;

    // Packet kind codes as carried on packet_kind.
    localparam logic KIND_EVT = 1'b0;
    localparam logic KIND_ACL = 1'b1;

    // Section codes as carried on section.
    localparam logic [1:0] SEC_TYPE = 2'd0;
    localparam logic [1:0] SEC_HDR  = 2'd1;
    localparam logic [1:0] SEC_PAY  = 2'd2;

    // Header byte positions, counted from zero after the type byte.
    localparam logic [2:0] HDR_IDX_EVT_LEN    = 3'd1;
    localparam logic [2:0] HDR_IDX_ACL_LEN_LO = 3'd2;
    localparam logic [2:0] HDR_IDX_ACL_LEN_HI = 3'd3;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_HDR  = 2'd1,
        PH_PAY  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_kind;
        logic [1:0] section;
        logic       first_of_packet;
        logic       last_of_packet;
        logic       bad_type;
    } t_result;

endpackage

// ----- sv/hciuh4_if.sv -----
// Input channel: one received UART byte per word.
interface hciuh4_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Output channel: one tagged byte per word.
interface hciuh4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_kind;
    logic [1:0] section;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       bad_type;

    modport source (output valid, output data_byte, output packet_kind, output section,
                    output first_of_packet, output last_of_packet, output bad_type,
                    input ready);
    modport sink   (input valid, input data_byte, input packet_kind, input section,
                    input first_of_packet, input last_of_packet, input bad_type,
                    output ready);
endinterface

// ----- sv/hciuh4_parser.sv -----
module hciuh4_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    output hciuh4_pkg::t_result o_result
);

    hciuh4_pkg::t_phase r_phase, n_phase;
    logic        r_kind, n_kind;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_remain, n_remain;

    logic        is_known;
    logic        hdr_done;
    logic [15:0] hdr_len;

    always_comb begin
        is_known = (i_byte == hciuh4_pkg::TYPE_EVT) || (i_byte == hciuh4_pkg::TYPE_ACL);
        if (r_kind == hciuh4_pkg::KIND_EVT) begin
            hdr_done = (r_hdr_cnt >= hciuh4_pkg::HDR_IDX_EVT_LEN);
            hdr_len  = {8'd0, i_byte};
        end else begin
            hdr_done = (r_hdr_cnt >= hciuh4_pkg::HDR_IDX_ACL_LEN_HI);
            hdr_len  = {i_byte, r_len_lo};
        end
    end

    // Next state.
    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_hdr_cnt = r_hdr_cnt;
        n_len_lo  = r_len_lo;
        n_remain  = r_remain;
        case (r_phase)
            hciuh4_pkg::PH_HDR: begin
                n_hdr_cnt = r_hdr_cnt + 3'd1;
                if (r_kind == hciuh4_pkg::KIND_ACL &&
                    r_hdr_cnt == hciuh4_pkg::HDR_IDX_ACL_LEN_LO) begin
                    n_len_lo = i_byte;
                end else if (hdr_done) begin
                    if (hdr_len == 16'd0) begin
                        n_phase = hciuh4_pkg::PH_TYPE;
                    end else begin
                        n_remain = hdr_len;
                        n_phase  = hciuh4_pkg::PH_PAY;
                    end
                end
            end
            hciuh4_pkg::PH_PAY: begin
                if (r_remain <= 16'd1) begin
                    n_remain = 16'd0;
                    n_phase  = hciuh4_pkg::PH_TYPE;
                end else begin
                    n_remain = r_remain - 16'd1;
                end
            end
            default: begin
                n_phase = hciuh4_pkg::PH_TYPE;
                if (is_known) begin
                    n_kind    = (i_byte == hciuh4_pkg::TYPE_ACL) ? hciuh4_pkg::KIND_ACL
                                                                 : hciuh4_pkg::KIND_EVT;
                    n_hdr_cnt = 3'd0;
                    n_len_lo  = 8'd0;
                    n_remain  = 16'd0;
                    n_phase   = hciuh4_pkg::PH_HDR;
                end
            end
        endcase
    end

    // Tags for the byte in hand.
    always_comb begin
        o_result                 = '0;
        o_result.data_byte       = i_byte;
        case (r_phase)
            hciuh4_pkg::PH_HDR: begin
                o_result.packet_kind    = r_kind;
                o_result.section        = hciuh4_pkg::SEC_HDR;
                o_result.last_of_packet = hdr_done && (hdr_len == 16'd0) &&
                    !(r_kind == hciuh4_pkg::KIND_ACL &&
                      r_hdr_cnt == hciuh4_pkg::HDR_IDX_ACL_LEN_LO);
            end
            hciuh4_pkg::PH_PAY: begin
                o_result.packet_kind    = r_kind;
                o_result.section        = hciuh4_pkg::SEC_PAY;
                o_result.last_of_packet = (r_remain <= 16'd1);
            end
            default: begin
                o_result.section         = hciuh4_pkg::SEC_TYPE;
                o_result.packet_kind     = (i_byte == hciuh4_pkg::TYPE_ACL);
                o_result.first_of_packet = is_known;
                o_result.bad_type        = !is_known;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= hciuh4_pkg::PH_TYPE;
            r_kind    <= hciuh4_pkg::KIND_EVT;
            r_hdr_cnt <= 3'd0;
            r_len_lo  <= 8'd0;
            r_remain  <= 16'd0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_hdr_cnt <= n_hdr_cnt;
            r_len_lo  <= n_len_lo;
            r_remain  <= n_remain;
        end
    end

endmodule

// ----- sv/hci_uart_h4_deframer.sv -----
// A byte accepted at a clock edge is offered as a tagged word from the next cycle.
// One byte per cycle while the sink keeps ready high, set by the single parse pass.
// A new byte is taken while the output register is empty or its word is taken that cycle.
// Reset (synchronous, active low) returns the parser to waiting for a type byte,
// clears the header and length state and empties the output register.
module hci_uart_h4_deframer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hciuh4_in_if.sink    i_in,
    hciuh4_out_if.source o_out
);

    hciuh4_pkg::t_result parse_res;
    hciuh4_pkg::t_result r_res;
    logic                r_valid;
    logic                take;

    // The output register frees up in the same cycle its word is taken, so a
    // steady stream passes at full rate as long as the sink keeps ready high.
    assign i_in.ready = !r_valid || o_out.ready;
    assign take       = i_in.valid && i_in.ready;

    // The parser holds the framing state and tags each byte in one pass; its
    // state only advances on an accepted word.
    hciuh4_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (i_in.rx_byte),
        .o_result (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload of the output register needs no reset: it is only seen with valid.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= parse_res;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.data_byte       = r_res.data_byte;
    assign o_out.packet_kind     = r_res.packet_kind;
    assign o_out.section         = r_res.section;
    assign o_out.first_of_packet = r_res.first_of_packet;
    assign o_out.last_of_packet  = r_res.last_of_packet;
    assign o_out.bad_type        = r_res.bad_type;

endmodule

// ----- verif/tb_hci_uart_h4_deframer.sv -----
module tb_hci_uart_h4_deframer;

    // The watchdog limit sits far above the slowest legal run. That run sends
    // some seven hundred words at most. Even with every word held up by the
    // longest sender gap and a long receiver stall, it stays well within the
    // limit.
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned RANDOM_ITEMS  = 400;
    localparam int unsigned CLOSING_ITEMS = 258;
    localparam int unsigned DRAIN_CYCLES  = 4;

    // Keeps its own copy of the parser state and predicts the tag of every byte
    // that the deframer accepts. The tagged words it expects are queued in
    // arrival order and checked one by one as the block hands them out.
    class h4_tag_book;
        hciuh4_pkg::t_phase  phase_q      = hciuh4_pkg::PH_TYPE;
        logic                kind_q       = hciuh4_pkg::KIND_EVT;
        logic [2:0]          hdr_seen     = 3'd0;
        logic [7:0]          len_low_q    = 8'h00;
        logic [15:0]         payload_left = 16'h0000;
        hciuh4_pkg::t_result expected_tags[$];
        int unsigned         fault_count  = 0;

        // The last header byte either closes the packet (no payload) or
        // arms the payload counter.
        function logic close_header(logic [15:0] len);
            if (len == 16'h0000) begin
                phase_q = hciuh4_pkg::PH_TYPE;
                return 1'b1;
            end
            payload_left = len;
            phase_q      = hciuh4_pkg::PH_PAY;
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b);
            hciuh4_pkg::t_result r;
            logic [2:0]          idx;
            r           = '0;
            r.data_byte = b;
            r.section   = hciuh4_pkg::SEC_TYPE;
            case (phase_q)
                hciuh4_pkg::PH_HDR: begin
                    idx           = hdr_seen;
                    r.packet_kind = kind_q;
                    r.section     = hciuh4_pkg::SEC_HDR;
                    hdr_seen      = hdr_seen + 3'd1;
                    if (kind_q == hciuh4_pkg::KIND_EVT) begin
                        if (idx >= hciuh4_pkg::HDR_IDX_EVT_LEN)
                            r.last_of_packet = close_header({8'h00, b});
                    end else if (idx == hciuh4_pkg::HDR_IDX_ACL_LEN_LO) begin
                        len_low_q = b;
                    end else if (idx >= hciuh4_pkg::HDR_IDX_ACL_LEN_HI) begin
                        r.last_of_packet = close_header({b, len_low_q});
                    end
                end
                hciuh4_pkg::PH_PAY: begin
                    r.packet_kind = kind_q;
                    r.section     = hciuh4_pkg::SEC_PAY;
                    if (payload_left <= 16'd1) begin
                        payload_left     = 16'h0000;
                        r.last_of_packet = 1'b1;
                        phase_q          = hciuh4_pkg::PH_TYPE;
                    end else begin
                        payload_left = payload_left - 16'd1;
                    end
                end
                default: begin
                    // Waiting for a type byte; an unused phase code is treated
                    // the same way.
                    phase_q = hciuh4_pkg::PH_TYPE;
                    if (b == hciuh4_pkg::TYPE_EVT || b == hciuh4_pkg::TYPE_ACL) begin
                        kind_q            = (b == hciuh4_pkg::TYPE_ACL) ? hciuh4_pkg::KIND_ACL
                                                                        : hciuh4_pkg::KIND_EVT;
                        r.packet_kind     = kind_q;
                        r.first_of_packet = 1'b1;
                        hdr_seen          = 3'd0;
                        len_low_q         = 8'h00;
                        payload_left      = 16'h0000;
                        phase_q           = hciuh4_pkg::PH_HDR;
                    end else begin
                        r.bad_type = 1'b1;
                    end
                end
            endcase
            expected_tags.push_back(r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fault_count++;
            end
        endfunction

        function void check_word(hciuh4_pkg::t_result got);
            hciuh4_pkg::t_result want;
            if (expected_tags.size() == 0) begin
                $error("word with data_byte %0h arrived with nothing expected", got.data_byte);
                fault_count++;
                return;
            end
            want = expected_tags.pop_front();
            check_field("data_byte",       32'(want.data_byte),       32'(got.data_byte));
            check_field("packet_kind",     32'(want.packet_kind),     32'(got.packet_kind));
            check_field("section",         32'(want.section),         32'(got.section));
            check_field("first_of_packet", 32'(want.first_of_packet), 32'(got.first_of_packet));
            check_field("last_of_packet",  32'(want.last_of_packet),  32'(got.last_of_packet));
            check_field("bad_type",        32'(want.bad_type),        32'(got.bad_type));
        endfunction

        function int unsigned waiting();
            return expected_tags.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hciuh4_in_if  rx_ch ();
    hciuh4_out_if tag_ch ();

    hci_uart_h4_deframer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rx_ch.sink),
        .o_out   (tag_ch.source)
    );

    h4_tag_book  book = new();
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;

    // Every input is given a known value at time zero, before the first edge.
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'h00;
        tag_ch.ready   = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver runs through segments of differing behaviour: fully ready,
    // coin-toss ready, a regular one-cycle stall, and a long
    // stall followed by readiness. Segments change at random so that stalls
    // land on type, header and payload bytes alike.
    int unsigned stall_mode   = 0;
    int unsigned segment_left = 0;
    int unsigned stall_period = 2;
    int unsigned seg_pos      = 0;
    int unsigned hold_low     = 0;

    always @(negedge i_clk) begin
        if (segment_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            segment_left = $urandom_range(10, 60);
            stall_period = $urandom_range(2, 5);
            hold_low     = $urandom_range(5, 20);
            seg_pos      = 0;
        end
        case (stall_mode)
            0:       tag_ch.ready <= 1'b1;
            1:       tag_ch.ready <= 1'($urandom_range(0, 1));
            2:       tag_ch.ready <= ((seg_pos % stall_period) != 0);
            default: tag_ch.ready <= (seg_pos >= hold_low);
        endcase
        seg_pos++;
        segment_left--;
    end

    // Outputs are sampled at the rising edge; a word is taken when valid and
    // ready are both high there.
    always @(posedge i_clk) begin
        if (i_rst_n && tag_ch.valid && tag_ch.ready)
            book.check_word('{data_byte:       tag_ch.data_byte,
                              packet_kind:     tag_ch.packet_kind,
                              section:         tag_ch.section,
                              first_of_packet: tag_ch.first_of_packet,
                              last_of_packet:  tag_ch.last_of_packet,
                              bad_type:        tag_ch.bad_type});
    end

    // Offers one byte and waits until the deframer takes it. The sender works
    // in bursts; between bursts valid drops for a random gap, which may be zero.
    // Called at a falling edge and returns at a falling edge.
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        book.note_byte(b);
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic push_payload(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    // Event packet: type byte, event code, one length byte, then the payload.
    task automatic send_event(input logic [7:0] len);
        push_byte(hciuh4_pkg::TYPE_EVT);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(len);
        push_payload(32'(len));
    endtask

    // ACL packet: type byte, two handle bytes, 16-bit length little-endian,
    // then the payload.
    task automatic send_acl(input logic [15:0] len);
        push_byte(hciuh4_pkg::TYPE_ACL);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        push_payload(32'(len));
    endtask

    // Random bytes with no framing; a stray type byte simply starts a packet.
    task automatic send_noise(input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int unsigned pick;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening: unknown type bytes at both extremes, zero-length
        // packets of both kinds (each followed straight away by a new type
        // byte), and short packets with extreme header and payload values.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h03);
        push_byte(hciuh4_pkg::TYPE_EVT);
        push_byte(8'h0E);
        push_byte(8'h00);
        push_byte(hciuh4_pkg::TYPE_ACL);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(hciuh4_pkg::TYPE_EVT);
        push_byte(8'hFF);
        push_byte(8'h01);
        push_byte(8'hAA);
        push_byte(hciuh4_pkg::TYPE_ACL);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'h55);
        push_byte(8'hFF);
        push_byte(8'h01);

        // Random part: mostly well-formed packets with random content and
        // short payloads, now and then a long one, mixed with raw noise.
        // Room is left for the closing packet.
        while (bytes_sent + CLOSING_ITEMS < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                send_event(8'((($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 6))));
            else if (pick < 7)
                send_acl(16'((($urandom_range(0, 19) == 0) ? $urandom_range(0, 300)
                                                           : $urandom_range(0, 6))));
            else
                send_noise($urandom_range(1, 4));
        end

        // The largest event length, once.
        send_event(8'hFF);
        rx_ch.valid <= 1'b0;

        while (book.waiting() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.fault_count == 0 && book.waiting() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/hciuh4_pkg.sv
sv/hciuh4_if.sv
sv/hciuh4_parser.sv
sv/hci_uart_h4_deframer.sv
verif/tb_hci_uart_h4_deframer.sv
